// ----- rtl/wall_distance_map_query_macros.svh -----
// Assertion macros shared by the wall distance map query RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef WALL_DISTANCE_MAP_QUERY_MACROS_SVH
`define WALL_DISTANCE_MAP_QUERY_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define WDMQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define WDMQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/wdmq_pkg.sv -----
package wdmq_pkg;

   // Request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Field widths
   localparam int ROW_W  = 7;
   localparam int CODE_W = 8;
   localparam int DIST_W = 13;

   // Cell code that marks a wall
   localparam logic [CODE_W-1:0] WALL_CODE = 8'h0F;

   // Result when no wall is near: 300 cm in sixteenths of cm
   localparam logic [DIST_W-1:0] NO_WALL_DIST = 13'd4800;

   // (16 * 10)^2: squared cells to squared sixteenths of cm
   localparam int                SCALE_W  = 15;
   localparam logic [SCALE_W-1:0] SCALE_SQ = 15'd25600;

   // Window offsets span -31..31, squared distance up to 2 * 31^2
   localparam int DR_W    = 6;
   localparam int D2_W    = 11;
   localparam int COORD_W = 10;

   // Scaled squared distance and its integer root
   localparam int PROD_W     = 26;
   localparam int SQRT_STEPS = 13;
   localparam int SQ_CNT_W   = 4;
   localparam int ROOT_W     = 13;

   // Command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef struct packed {
      logic             is_query;
      logic             wall;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } fe_out_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] operand;
   } sq_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sq_rsp_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_MUL,
      BK_SQ_START,
      BK_SQ_WAIT
   } bk_state_type;

endpackage

// ----- rtl/wdmq_ram.sv -----
module wdmq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/wdmq_front.sv -----
`include "wall_distance_map_query_macros.svh"

module wdmq_front #(
   parameter int MAP_ROWS = 64,
   parameter int MAP_COLS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic [6:0]               req_row,
   input  logic [6:0]               req_col,
   input  logic [7:0]               req_cell_code,
   input  logic                     init_done,
   input  logic                     q_pop,
   output wdmq_pkg::fe_out_type     q_out
);
   import wdmq_pkg::*;

   q_entry_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 accept;
   logic                 in_grid;
   logic                 keep;
   logic                 push;
   q_entry_type          entry;

   // Stall while the map is being cleared or the queue is full
   assign req_stall = !init_done || (count_ff == Q_CNT_W'(Q_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Classify the beat: drop loads that fall outside the grid
   assign in_grid = ({2'b00, req_row} < 9'(MAP_ROWS)) && ({2'b00, req_col} < 9'(MAP_COLS));
   assign keep    = (req_type == REQ_QUERY) || in_grid;
   assign push    = accept && keep;

   assign entry.is_query = (req_type == REQ_QUERY);
   assign entry.wall     = (req_cell_code == WALL_CODE);
   assign entry.row      = req_row;
   assign entry.col      = req_col;

   // Advance queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = mem_ff[rd_ptr_ff];

   `WDMQ_ASSERT_IMPL(a_pop_nonempty, q_pop, count_ff != '0, "pop from empty command queue")

endmodule

// ----- rtl/wdmq_sqrt.sv -----
`include "wall_distance_map_query_macros.svh"

module wdmq_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  wdmq_pkg::sq_req_type sq_req,
   output wdmq_pkg::sq_rsp_type sq_rsp
);
   import wdmq_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]   rem_ff, rem_in;
   logic [PROD_W:0]     res_ff, res_in;
   logic [PROD_W-1:0]   sbit_ff, sbit_in;
   logic [PROD_W:0]     trial;

   // One root bit per cycle, from one bit pair of the operand
   assign trial = res_ff + {1'b0, sbit_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      sbit_in = sbit_ff;
      if (sq_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = sq_req.operand;
         res_in  = '0;
         sbit_in = PROD_W'(1) << (2 * (SQRT_STEPS - 1));
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[PROD_W-1:0];
            res_in = (res_ff >> 1) + {1'b0, sbit_ff};
         end else begin
            res_in = res_ff >> 1;
         end
         sbit_in = sbit_ff >> 2;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      sbit_ff <= sbit_in;
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = res_ff[ROOT_W-1:0];

   `WDMQ_ASSERT_IMPL(a_no_restart, sq_req.start, !busy_ff, "root unit restarted while busy")

endmodule

// ----- rtl/wdmq_back.sv -----
`include "wall_distance_map_query_macros.svh"

module wdmq_back #(
   parameter int MAP_ROWS      = 64,
   parameter int MAP_COLS      = 64,
   parameter int BORDER_CELLS  = 10,
   parameter int SEARCH_RADIUS = 19,
   localparam int DEPTH = MAP_ROWS * MAP_COLS,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wdmq_pkg::fe_out_type q_in,
   output logic                 q_pop,
   output logic                 init_done,
   output logic                 ram_we,
   output logic [AW-1:0]        ram_waddr,
   output logic                 ram_wdata,
   output logic                 ram_re,
   output logic [AW-1:0]        ram_raddr,
   input  logic                 ram_rdata,
   output wdmq_pkg::sq_req_type sq_req,
   input  wdmq_pkg::sq_rsp_type sq_rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [12:0]          rsp_distance
);
   import wdmq_pkg::*;

   localparam int PW = AW + 8;
   localparam logic signed [DR_W-1:0]    R_POS  = DR_W'(SEARCH_RADIUS);
   localparam logic signed [DR_W-1:0]    R_NEG  = -R_POS;
   localparam logic signed [COORD_W-1:0] B_S    = COORD_W'(BORDER_CELLS);
   localparam logic signed [COORD_W-1:0] ROWS_S = COORD_W'(MAP_ROWS);
   localparam logic signed [COORD_W-1:0] COLS_S = COORD_W'(MAP_COLS);

   bk_state_type             state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [ROW_W-1:0]         qrow_ff, qrow_in;
   logic [ROW_W-1:0]         qcol_ff, qcol_in;
   logic signed [DR_W-1:0]   dr_ff, dr_in;
   logic signed [DR_W-1:0]   dc_ff, dc_in;
   logic                     p_valid_ff, p_valid_in;
   logic [D2_W-1:0]          p_d2_ff, p_d2_in;
   logic                     found_ff, found_in;
   logic [D2_W-1:0]          best_ff, best_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;

   logic signed [COORD_W-1:0] x, y;
   logic                      in_map;
   logic [PW-1:0]             scan_addr, load_addr;
   logic [DR_W-1:0]           mag_r, mag_c;
   logic [2*(DR_W-1)-1:0]     sq_r, sq_c;
   logic [D2_W-1:0]           d2;

   // Map cell under the window position
   assign x = $signed({{(COORD_W-ROW_W){1'b0}}, qrow_ff})
              + $signed({{(COORD_W-DR_W){dr_ff[DR_W-1]}}, dr_ff}) - B_S;
   assign y = $signed({{(COORD_W-ROW_W){1'b0}}, qcol_ff})
              + $signed({{(COORD_W-DR_W){dc_ff[DR_W-1]}}, dc_ff}) - B_S;
   assign in_map = (x >= 0) && (x < ROWS_S) && (y >= 0) && (y < COLS_S);

   assign scan_addr = PW'(x[7:0]) * PW'(MAP_COLS) + PW'(y[7:0]);
   assign load_addr = PW'(q_in.entry.row) * PW'(MAP_COLS) + PW'(q_in.entry.col);

   // Squared offset of the window position
   assign mag_r = dr_ff[DR_W-1] ? DR_W'(-dr_ff) : dr_ff;
   assign mag_c = dc_ff[DR_W-1] ? DR_W'(-dc_ff) : dc_ff;
   assign sq_r  = (2*(DR_W-1))'(mag_r[DR_W-2:0]) * (2*(DR_W-1))'(mag_r[DR_W-2:0]);
   assign sq_c  = (2*(DR_W-1))'(mag_c[DR_W-2:0]) * (2*(DR_W-1))'(mag_c[DR_W-2:0]);
   assign d2    = D2_W'(sq_r) + D2_W'(sq_c);

   // Sequence clear, load, scan and root steps
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      qrow_in      = qrow_ff;
      qcol_in      = qcol_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      p_valid_in   = 1'b0;
      p_d2_in      = d2;
      found_in     = found_ff;
      best_in      = best_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = scan_addr[AW-1:0];
      sq_req.start   = 1'b0;
      sq_req.operand = prod_ff;

      // Keep the nearest wall seen so far
      if (p_valid_ff && ram_rdata && (!found_ff || (p_d2_ff < best_ff))) begin
         found_in = 1'b1;
         best_in  = p_d2_ff;
      end

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BK_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_in.valid) begin
               if (!q_in.entry.is_query) begin
                  q_pop     = 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = load_addr[AW-1:0];
                  ram_wdata = q_in.entry.wall;
               end else if (!rsp_valid_ff) begin
                  q_pop    = 1'b1;
                  qrow_in  = q_in.entry.row;
                  qcol_in  = q_in.entry.col;
                  dr_in    = R_NEG;
                  dc_in    = R_NEG;
                  found_in = 1'b0;
                  state_in = BK_SCAN;
               end
            end
         end
         BK_SCAN: begin
            ram_re     = in_map;
            p_valid_in = in_map;
            if (dc_ff == R_POS) begin
               dc_in = R_NEG;
               if (dr_ff == R_POS) begin
                  state_in = BK_DRAIN;
               end else begin
                  dr_in = dr_ff + 1'b1;
               end
            end else begin
               dc_in = dc_ff + 1'b1;
            end
         end
         BK_DRAIN: begin
            state_in = BK_MUL;
         end
         BK_MUL: begin
            if (found_ff) begin
               prod_in  = PROD_W'(best_ff) * PROD_W'(SCALE_SQ);
               state_in = BK_SQ_START;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = NO_WALL_DIST;
               state_in     = BK_IDLE;
            end
         end
         BK_SQ_START: begin
            sq_req.start = 1'b1;
            state_in     = BK_SQ_WAIT;
         end
         BK_SQ_WAIT: begin
            if (sq_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = (sq_rsp.root > NO_WALL_DIST) ? NO_WALL_DIST : sq_rsp.root;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         p_valid_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         p_valid_ff   <= p_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qrow_ff     <= qrow_in;
      qcol_ff     <= qcol_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      p_d2_ff     <= p_d2_in;
      best_ff     <= best_in;
      prod_ff     <= prod_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign init_done    = (state_ff != BK_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;

   `WDMQ_ASSERT_IMPL(a_scan_no_pending, state_ff == BK_SCAN, !rsp_valid_ff, "scan with result pending")
   `WDMQ_ASSERT_IMPL(a_root_when_waiting, sq_rsp.done, state_ff == BK_SQ_WAIT, "root done out of step")
   `WDMQ_ASSERT_NEXT(a_query_starts_scan, q_pop && q_in.entry.is_query, (state_ff == BK_SCAN) && !found_ff, "query did not start a fresh scan")

endmodule

// ----- rtl/wall_distance_map_query.sv -----
// Wall distance map query. Load beats (req_type 0) write one wall flag of the
// MAP_ROWS x MAP_COLS map (code 0x0F is a wall; loads off the grid are dropped)
// and give no result. Query beats (req_type 1) name a cell of the map grown by
// BORDER_CELLS on every side and return, in sixteenths of cm, ten times the
// Euclidean distance to the nearest wall within a square window of radius
// SEARCH_RADIUS, rounded down, or 4800 if there is none or it is 300 cm or more
// away. After reset the map is cleared one cell per cycle, with req_stall high.
// Beats enter a two-entry queue. A load writes its flag when it leaves the queue;
// a query runs the window scan at one cell per cycle through the single read
// port of the map RAM, followed by the square-root unit. The result sits in an
// output register while the next beats are queued.
module wall_distance_map_query #(
   parameter int MAP_ROWS      = 64,
   parameter int MAP_COLS      = 64,
   parameter int BORDER_CELLS  = 10,
   parameter int SEARCH_RADIUS = 19
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [6:0]  req_row,
   input  logic [6:0]  req_col,
   input  logic [7:0]  req_cell_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_distance
);
   import wdmq_pkg::*;

   localparam int DEPTH = MAP_ROWS * MAP_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   fe_out_type    q_out;
   logic          q_pop;
   logic          init_done;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic          ram_rdata;
   sq_req_type    sq_req;
   sq_rsp_type    sq_rsp;

   // Accept and classify beats into the command queue
   wdmq_front #(
      .MAP_ROWS (MAP_ROWS),
      .MAP_COLS (MAP_COLS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_code (req_cell_code),
      .init_done     (init_done),
      .q_pop         (q_pop),
      .q_out         (q_out)
   );

   // Execute loads and window scans
   wdmq_back #(
      .MAP_ROWS      (MAP_ROWS),
      .MAP_COLS      (MAP_COLS),
      .BORDER_CELLS  (BORDER_CELLS),
      .SEARCH_RADIUS (SEARCH_RADIUS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_in         (q_out),
      .q_pop        (q_pop),
      .init_done    (init_done),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .sq_req       (sq_req),
      .sq_rsp       (sq_rsp),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_distance (rsp_distance)
   );

   // Integer square root of the scaled squared distance
   wdmq_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   // Wall flag map
   wdmq_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ----- test/wall_distance_map_query_checker.sv -----
module wall_distance_map_query_checker import wdmq_pkg::*; #(
   parameter int MAP_ROWS      = 64,
   parameter int MAP_COLS      = 64,
   parameter int BORDER_CELLS  = 10,
   parameter int SEARCH_RADIUS = 19
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_type,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [ROW_W-1:0]  req_col,
   input  logic [CODE_W-1:0] req_cell_code,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [DIST_W-1:0] rsp_distance,
   output int                fail_count,
   output int                pending_count,
   output int                load_count,
   output int                query_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Wall flags of the interior grid as the block should hold them
   logic              wall_flags [MAP_ROWS*MAP_COLS];
   logic [DIST_W-1:0] queued_distances [$];
   int                errors;
   int                loads;
   int                queries;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      load_count    = 0;
      query_count   = 0;
      errors        = 0;
      loads         = 0;
      queries       = 0;
      foreach (wall_flags[i]) wall_flags[i] = 1'b0;
   end

   // Nearest wall in the square window, scaled to sixteenths of cm and rounded down
   function automatic logic [DIST_W-1:0] nearest_wall_distance(input int qrow, input int qcol);
      int          best_d2;
      int          x;
      int          y;
      logic [31:0] scaled;
      logic [31:0] root;
      logic [31:0] trial;
      best_d2 = -1;
      for (int dr = -SEARCH_RADIUS; dr <= SEARCH_RADIUS; dr++) begin
         x = qrow + dr - BORDER_CELLS;
         if (x < 0 || x >= MAP_ROWS) continue;
         for (int dc = -SEARCH_RADIUS; dc <= SEARCH_RADIUS; dc++) begin
            y = qcol + dc - BORDER_CELLS;
            if (y < 0 || y >= MAP_COLS) continue;
            if (wall_flags[x*MAP_COLS+y] && (best_d2 < 0 || dr*dr + dc*dc < best_d2))
               best_d2 = dr*dr + dc*dc;
         end
      end
      if (best_d2 < 0) return NO_WALL_DIST;
      scaled = best_d2 * SCALE_SQ;
      // Build the floor root one bit at a time from the top
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (trial * trial <= scaled) root = trial;
      end
      if (root > NO_WALL_DIST) root = NO_WALL_DIST;
      return root[DIST_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [DIST_W-1:0] want;
      if (reset) begin
         foreach (wall_flags[i]) wall_flags[i] = 1'b0;
         queued_distances.delete();
      end else begin
         // Compare the result beat with the oldest queued distance
         if (rsp_valid && !rsp_stall) begin
            if (queued_distances.size() == 0) begin
               $error("distance: result beat with no query waiting, actual %0d", rsp_distance);
               errors++;
            end else begin
               want = queued_distances.pop_front();
               if (rsp_distance !== want) begin
                  $error("distance mismatch: expected %0d, actual %0d", want, rsp_distance);
                  errors++;
               end
            end
         end
         // Apply a load to the map, or queue the distance a query should return
         if (req_valid && !req_stall) begin
            if (req_type == REQ_LOAD) begin
               loads++;
               if (req_row < MAP_ROWS && req_col < MAP_COLS)
                  wall_flags[req_row*MAP_COLS+req_col] = (req_cell_code == WALL_CODE);
            end else begin
               queries++;
               queued_distances.push_back(nearest_wall_distance(req_row, req_col));
            end
         end
      end
      fail_count    <= errors;
      pending_count <= queued_distances.size();
      load_count    <= loads;
      query_count   <= queries;
   end

endmodule

// ----- test/wall_distance_map_query_tb.sv -----
module wall_distance_map_query_tb import wdmq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_ROWS       = 64;
   localparam int MAP_COLS       = 64;
   localparam int BORDER_CELLS   = 10;
   localparam int SEARCH_RADIUS  = 19;
   localparam int ITEM_TOTAL     = 370;
   localparam int DRAIN_CYCLES   = 1600;
   localparam int WATCHDOG_LIMIT = 20000;

   logic              clock;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic              req_type      = REQ_LOAD;
   logic [ROW_W-1:0]  req_row       = '0;
   logic [ROW_W-1:0]  req_col       = '0;
   logic [CODE_W-1:0] req_cell_code = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [DIST_W-1:0] rsp_distance;

   int fail_count;
   int pending_count;
   int load_count;
   int query_count;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int beats_counted  = 0;
   int idle_cycles    = 0;

   wall_distance_map_query #(
      .MAP_ROWS(MAP_ROWS),
      .MAP_COLS(MAP_COLS),
      .BORDER_CELLS(BORDER_CELLS),
      .SEARCH_RADIUS(SEARCH_RADIUS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_row(req_row),
      .req_col(req_col),
      .req_cell_code(req_cell_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance)
   );

   wall_distance_map_query_checker #(
      .MAP_ROWS(MAP_ROWS),
      .MAP_COLS(MAP_COLS),
      .BORDER_CELLS(BORDER_CELLS),
      .SEARCH_RADIUS(SEARCH_RADIUS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_row(req_row),
      .req_col(req_col),
      .req_cell_code(req_cell_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .load_count(load_count),
      .query_count(query_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // End the run when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one beat after random idle cycles and hold it until accepted
   task automatic send_beat(input logic kind, input logic [ROW_W-1:0] row,
                            input logic [ROW_W-1:0] col, input logic [CODE_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_row       <= row;
      req_col       <= col;
      req_cell_code <= code;
      do @(posedge clock); while (req_stall);
      beats_counted++;
   endtask

   // Drop valid and hold off until every queued distance has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int center_row;
      int center_col;
      int pick_row;
      int pick_col;
      int burst;
      int target;
      logic [CODE_W-1:0] code;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct  <= 13;
      recv_stall_pct <= 57;

      // Empty map gives the no-wall distance
      send_beat(REQ_QUERY, 7'd0, 7'd0, 8'h00);
      // One wall in the corner: on it, diagonal, window corner, just outside the window
      send_beat(REQ_LOAD, 7'd0, 7'd0, WALL_CODE);
      send_beat(REQ_QUERY, 7'd10, 7'd10, 8'h00);
      send_beat(REQ_QUERY, 7'd0, 7'd0, 8'hFF);
      send_beat(REQ_QUERY, 7'd29, 7'd29, 8'h00);
      send_beat(REQ_QUERY, 7'd30, 7'd10, 8'h00);
      // Non-wall code then wall at the far corner, queried from the border and far away
      send_beat(REQ_LOAD, 7'd63, 7'd63, 8'hFF);
      send_beat(REQ_LOAD, 7'd63, 7'd63, WALL_CODE);
      send_beat(REQ_QUERY, 7'd83, 7'd83, 8'h00);
      send_beat(REQ_QUERY, 7'd127, 7'd127, 8'h00);
      // Loads off the grid must leave the map alone
      send_beat(REQ_LOAD, 7'd64, 7'd0, WALL_CODE);
      send_beat(REQ_LOAD, 7'd127, 7'd127, WALL_CODE);
      send_beat(REQ_LOAD, 7'd0, 7'd64, WALL_CODE);
      send_beat(REQ_QUERY, 7'd74, 7'd10, 8'h00);
      // Clearing a wall, and codes close to the wall code
      send_beat(REQ_LOAD, 7'd0, 7'd0, 8'h00);
      send_beat(REQ_QUERY, 7'd10, 7'd10, 8'h00);
      send_beat(REQ_LOAD, 7'd5, 7'd5, 8'h0E);
      send_beat(REQ_LOAD, 7'd5, 7'd6, 8'h8F);
      send_beat(REQ_QUERY, 7'd15, 7'd16, 8'h00);
      // Two walls, the nearer one wins
      send_beat(REQ_LOAD, 7'd20, 7'd20, WALL_CODE);
      send_beat(REQ_LOAD, 7'd21, 7'd22, WALL_CODE);
      send_beat(REQ_QUERY, 7'd30, 7'd31, 8'h00);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase > 0) wait_for_results();
         send_idle_pct  <= (phase == 0) ? 13 : (phase == 1) ? 57 : 0;
         recv_stall_pct <= (phase == 0) ? 57 : (phase == 1) ? 13 : 0;
         target = (phase == 2) ? ITEM_TOTAL : (phase + 1) * 125;
         while (beats_counted < target) begin
            if ($urandom_range(99) < 75) begin
               // Scatter a few cells around a spot, then query near it
               center_row = $urandom_range(MAP_ROWS - 1);
               center_col = $urandom_range(MAP_COLS - 1);
               burst = $urandom_range(5, 1);
               repeat (burst) begin
                  pick_row = center_row + $urandom_range(24) - 12;
                  pick_col = center_col + $urandom_range(24) - 12;
                  code = ($urandom_range(99) < 65) ? WALL_CODE : CODE_W'($urandom);
                  send_beat(REQ_LOAD, pick_row[ROW_W-1:0], pick_col[ROW_W-1:0], code);
               end
               pick_row = center_row + BORDER_CELLS + $urandom_range(44) - 22;
               pick_col = center_col + BORDER_CELLS + $urandom_range(44) - 22;
               send_beat(REQ_QUERY, pick_row[ROW_W-1:0], pick_col[ROW_W-1:0],
                         CODE_W'($urandom));
            end else begin
               // Noise: any load or query over the full field ranges
               send_beat(($urandom_range(1) == 0) ? REQ_LOAD : REQ_QUERY,
                         ROW_W'($urandom_range(127)), ROW_W'($urandom_range(127)),
                         CODE_W'($urandom));
            end
         end
      end

      // Drain, then watch a while for stray result beats
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d load beats and %0d queries in three stall mixes,", load_count,
               query_count);
      $display("including off-grid loads, cleared walls and queries beyond the border.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- wall_distance_map_query.f -----
+incdir+rtl
rtl/wdmq_pkg.sv
rtl/wdmq_ram.sv
rtl/wdmq_front.sv
rtl/wdmq_sqrt.sv
rtl/wdmq_back.sv
rtl/wall_distance_map_query.sv
test/wall_distance_map_query_checker.sv
test/wall_distance_map_query_tb.sv
